### sv/imm_pkg.sv
// ----------------------------------------------------------------------------
// imm_pkg
// Shared types, constants and helpers for the integer matrix multiplier.
// ----------------------------------------------------------------------------
package imm_pkg;

  localparam int MAX_DIM   = 8;
  localparam int ELEM_BITS = 16;

  localparam int CFG_W   = 4;
  localparam int RES_W   = 35;
  localparam int DIM_W   = $clog2(MAX_DIM);
  localparam int EFF_W   = $clog2(MAX_DIM + 1);
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = ADDR_W + 1;
  localparam int TOT_W   = ADDR_W + 2;
  localparam int PROD_W  = 2 * ELEM_BITS;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    REG_ROWS_A,
    REG_COLS_A,
    REG_ROWS_B,
    REG_COLS_B
  } cfg_reg_e;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_e;

  typedef struct packed {
    logic             valid;
    logic             first;
    logic             lastk;
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] col;
    logic             last;
  } mac_ctl_t;

  function automatic logic [EFF_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
    logic [EFF_W-1:0] r;
    if (v == '0) begin
      r = EFF_W'(1);
    end else if (int'(v) > MAX_DIM) begin
      r = EFF_W'(MAX_DIM);
    end else begin
      r = EFF_W'(v);
    end
    return r;
  endfunction

endpackage

### sv/integer_matrix_multiply.sv
// ----------------------------------------------------------------------------
// integer_matrix_multiply
// Signed matrix product C = A x B on one shared multiply-accumulate unit.
//
// Set rows_a, cols_a, rows_b and cols_b over the APB port (byte addresses
// 0, 4, 8, 12) while the block is idle; any write restarts loading.
// Feed elements with start while busy is low, A row-major then B row-major,
// one word per cycle. The word that completes B raises busy. The sequencer
// then walks i, j, k and issues one multiply-accumulate per cycle through
// the RAM read, multiply and accumulate stages. Each C element is strobed
// on result_valid_o for one cycle with its row and column, in row-major
// order, last_o on the final one; busy drops as the final result is shown.
// If cols_a and rows_b differ, every accepted word yields one dim_error_o
// result in the next cycle and nothing is stored.
// The receiver cannot stall: results are never held.
// Reset sets all dimensions to 1 and clears the load count.
// ----------------------------------------------------------------------------
module integer_matrix_multiply
  import imm_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [PADDR_W-1:0]          paddr,
  input  logic [PDATA_W-1:0]          pwdata,
  output logic [PDATA_W-1:0]          prdata,
  output logic                        pready,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [ELEM_BITS-1:0] element_i,
  output logic                        result_valid_o,
  output logic signed [RES_W-1:0]     product_value_o,
  output logic [2:0]                  out_row_o,
  output logic [2:0]                  out_col_o,
  output logic                        last_o,
  output logic                        dim_error_o
);

  logic [CFG_W-1:0] rows_a_q, cols_a_q, rows_b_q, cols_b_q;
  logic [EFF_W-1:0] ra, ca, rb, cb;
  logic [DIM_W-1:0] ra_m1, ca_m1, cb_m1;
  logic [CNT_W-1:0] na;
  logic [TOT_W-1:0] total;
  logic [CNT_W-1:0] load_q, load_d;
  logic             cfg_we;
  cfg_reg_e         cfg_idx;
  logic             accept, mismatch, load_done;
  logic             left_we, right_we;
  logic [ADDR_W-1:0] left_waddr, right_waddr;

  seq_state_e        state_q, state_d;
  logic [DIM_W-1:0]  i_q, i_d, j_q, j_d, k_q, k_d;
  logic [ADDR_W-1:0] base_q, base_d, a_ptr_q, a_ptr_d, b_ptr_q, b_ptr_d;
  mac_ctl_t          ctl_issue, ctl_rd_q, ctl_res;
  logic [ELEM_BITS-1:0] a_rd, b_rd;
  logic signed [RES_W-1:0] sum;

  logic                    res_valid_q;
  logic signed [RES_W-1:0] res_value_q;
  logic [2:0]              res_row_q, res_col_q;
  logic                    res_last_q, res_err_q;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = cfg_reg_e'(paddr[3:2]);

  always_comb begin
    unique case (cfg_idx)
      REG_ROWS_A: prdata = PDATA_W'(rows_a_q);
      REG_COLS_A: prdata = PDATA_W'(cols_a_q);
      REG_ROWS_B: prdata = PDATA_W'(rows_b_q);
      REG_COLS_B: prdata = PDATA_W'(cols_b_q);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q <= CFG_W'(1);
      cols_a_q <= CFG_W'(1);
      rows_b_q <= CFG_W'(1);
      cols_b_q <= CFG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ROWS_A: rows_a_q <= pwdata[CFG_W-1:0];
        REG_COLS_A: cols_a_q <= pwdata[CFG_W-1:0];
        REG_ROWS_B: rows_b_q <= pwdata[CFG_W-1:0];
        REG_COLS_B: cols_b_q <= pwdata[CFG_W-1:0];
      endcase
    end
  end

  assign ra    = eff_dim(rows_a_q);
  assign ca    = eff_dim(cols_a_q);
  assign rb    = eff_dim(rows_b_q);
  assign cb    = eff_dim(cols_b_q);
  assign ra_m1 = DIM_W'(ra - EFF_W'(1));
  assign ca_m1 = DIM_W'(ca - EFF_W'(1));
  assign cb_m1 = DIM_W'(cb - EFF_W'(1));
  assign na    = CNT_W'(ra) * CNT_W'(ca);
  assign total = TOT_W'(na) + TOT_W'(rb) * TOT_W'(cb);

  // Load path
  assign accept    = start & ~busy;
  assign mismatch  = (ca != rb);
  assign load_done = (TOT_W'(load_q) + TOT_W'(1)) >= total;
  assign left_we   = accept & ~mismatch & (load_q < na);
  assign right_we  = accept & ~mismatch & ~(load_q < na);
  assign left_waddr  = load_q[ADDR_W-1:0];
  assign right_waddr = ADDR_W'(load_q - na);

  always_comb begin
    load_d = load_q;
    if (cfg_we) begin
      load_d = '0;
    end else if (accept && !mismatch) begin
      load_d = load_done ? '0 : CNT_W'(load_q + CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= '0;
    end else begin
      load_q <= load_d;
    end
  end

  imm_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (left_we),
    .waddr_i (left_waddr),
    .wdata_i (element_i),
    .raddr_i (a_ptr_q),
    .rdata_o (a_rd)
  );

  imm_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_right_ram (
    .clk_i   (clk_i),
    .we_i    (right_we),
    .waddr_i (right_waddr),
    .wdata_i (element_i),
    .raddr_i (b_ptr_q),
    .rdata_o (b_rd)
  );

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SEQ_IDLE;
      i_q      <= '0;
      j_q      <= '0;
      k_q      <= '0;
      base_q   <= '0;
      a_ptr_q  <= '0;
      b_ptr_q  <= '0;
      ctl_rd_q <= '0;
    end else begin
      state_q  <= state_d;
      i_q      <= i_d;
      j_q      <= j_d;
      k_q      <= k_d;
      base_q   <= base_d;
      a_ptr_q  <= a_ptr_d;
      b_ptr_q  <= b_ptr_d;
      ctl_rd_q <= ctl_issue;
    end
  end

  always_comb begin
    state_d   = state_q;
    i_d       = i_q;
    j_d       = j_q;
    k_d       = k_q;
    base_d    = base_q;
    a_ptr_d   = a_ptr_q;
    b_ptr_d   = b_ptr_q;
    ctl_issue = '0;
    unique case (state_q)
      SEQ_IDLE: begin
        if (accept && !mismatch && load_done) begin
          state_d = SEQ_RUN;
          i_d     = '0;
          j_d     = '0;
          k_d     = '0;
          base_d  = '0;
          a_ptr_d = '0;
          b_ptr_d = '0;
        end
      end
      SEQ_RUN: begin
        ctl_issue.valid = 1'b1;
        ctl_issue.first = (k_q == '0);
        ctl_issue.lastk = (k_q == ca_m1);
        ctl_issue.row   = i_q;
        ctl_issue.col   = j_q;
        ctl_issue.last  = (i_q == ra_m1) && (j_q == cb_m1);
        if (k_q != ca_m1) begin
          k_d     = DIM_W'(k_q + DIM_W'(1));
          a_ptr_d = ADDR_W'(a_ptr_q + ADDR_W'(1));
          b_ptr_d = ADDR_W'(b_ptr_q + ADDR_W'(cb));
        end else begin
          k_d = '0;
          if (j_q != cb_m1) begin
            j_d     = DIM_W'(j_q + DIM_W'(1));
            a_ptr_d = base_q;
            b_ptr_d = ADDR_W'(j_q) + ADDR_W'(1);
          end else begin
            j_d     = '0;
            b_ptr_d = '0;
            base_d  = ADDR_W'(base_q + ADDR_W'(ca));
            a_ptr_d = ADDR_W'(base_q + ADDR_W'(ca));
            if (i_q != ra_m1) begin
              i_d = DIM_W'(i_q + DIM_W'(1));
            end else begin
              state_d = SEQ_IDLE;
            end
          end
        end
      end
    endcase
  end

  imm_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .a_i    (a_rd),
    .b_i    (b_rd),
    .ctl_i  (ctl_rd_q),
    .sum_o  (sum),
    .ctl_o  (ctl_res)
  );

  assign busy = (state_q != SEQ_IDLE) | ctl_rd_q.valid | ctl_res.valid;

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= (ctl_res.valid & ctl_res.lastk) | (accept & mismatch);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_res.valid && ctl_res.lastk) begin
      res_value_q <= sum;
      res_row_q   <= 3'(ctl_res.row);
      res_col_q   <= 3'(ctl_res.col);
      res_last_q  <= ctl_res.last;
      res_err_q   <= 1'b0;
    end else if (accept && mismatch) begin
      res_value_q <= '0;
      res_row_q   <= '0;
      res_col_q   <= '0;
      res_last_q  <= 1'b0;
      res_err_q   <= 1'b1;
    end
  end

  assign result_valid_o  = res_valid_q;
  assign product_value_o = res_value_q;
  assign out_row_o       = res_row_q;
  assign out_col_o       = res_col_q;
  assign last_o          = res_last_q;
  assign dim_error_o     = res_err_q;

endmodule

### sv/imm_ram.sv
// ----------------------------------------------------------------------------
// imm_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module imm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### sv/imm_mac.sv
// ----------------------------------------------------------------------------
// imm_mac
// Shared multiply-accumulate unit: registered product, then running sum.
// ----------------------------------------------------------------------------
module imm_mac
  import imm_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic signed [ELEM_BITS-1:0] a_i,
  input  logic signed [ELEM_BITS-1:0] b_i,
  input  mac_ctl_t                    ctl_i,
  output logic signed [RES_W-1:0]     sum_o,
  output mac_ctl_t                    ctl_o
);

  logic signed [PROD_W-1:0] prod_q;
  logic signed [RES_W-1:0]  acc_q;
  logic signed [RES_W-1:0]  acc_d;
  mac_ctl_t                 ctl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    if (ctl_q.valid) begin
      acc_q <= acc_d;
    end
  end

  always_comb begin
    if (ctl_q.first) begin
      acc_d = RES_W'(prod_q);
    end else begin
      acc_d = acc_q + RES_W'(prod_q);
    end
  end

  assign sum_o = acc_d;
  assign ctl_o = ctl_q;

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the signed integer matrix multiplier.
//
// A small product board predicts every C element from the words fed in and
// the shape registers written over APB, then checks each strobed result in
// order. A short directed part covers the element extremes, clamped shape
// values, an inner-dimension mismatch and a run abandoned by a register
// write. It is followed by random shapes with random sender gaps.
// ----------------------------------------------------------------------------
module tb_top;
  import imm_pkg::*;

  localparam int N_WORDS = 260;

  typedef struct packed {
    logic signed [RES_W-1:0] value;
    logic [2:0]              row;
    logic [2:0]              col;
    logic                    last;
    logic                    err;
  } c_elem_t;

  class prod_board;
    logic [CFG_W-1:0]            dim [4];
    logic signed [ELEM_BITS-1:0] a_store [DEPTH];
    logic signed [ELEM_BITS-1:0] b_store [DEPTH];
    int unsigned                 loaded;
    c_elem_t                     pending_q [$];
    int unsigned                 errors;

    function new();
      foreach (dim[i]) dim[i] = 1;
      loaded = 0;
      errors = 0;
    endfunction

    function int unsigned eff(cfg_reg_e r);
      int unsigned v;
      v = dim[int'(r)];
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return v;
    endfunction

    function void set_dim(cfg_reg_e r, logic [CFG_W-1:0] v);
      dim[int'(r)] = v;
      loaded = 0;
    endfunction

    function int unsigned run_words();
      if (eff(REG_COLS_A) != eff(REG_ROWS_B)) return 0;
      return eff(REG_ROWS_A) * eff(REG_COLS_A) + eff(REG_ROWS_B) * eff(REG_COLS_B);
    endfunction

    function void note_word(logic signed [ELEM_BITS-1:0] w);
      int unsigned ra, ca, cb, na;
      longint      acc;
      c_elem_t     e;
      ra = eff(REG_ROWS_A);
      ca = eff(REG_COLS_A);
      cb = eff(REG_COLS_B);
      if (run_words() == 0) begin
        e = '0;
        e.err = 1'b1;
        pending_q.push_back(e);
        return;
      end
      na = ra * ca;
      if (loaded < na) a_store[loaded] = w;
      else b_store[loaded - na] = w;
      if (loaded + 1 < run_words()) begin
        loaded++;
        return;
      end
      loaded = 0;
      for (int i = 0; i < ra; i++) begin
        for (int j = 0; j < cb; j++) begin
          acc = 0;
          for (int k = 0; k < ca; k++) begin
            acc += longint'(a_store[i*ca+k]) * longint'(b_store[k*cb+j]);
          end
          e.value = acc[RES_W-1:0];
          e.row   = 3'(i);
          e.col   = 3'(j);
          e.last  = (i + 1 == ra) && (j + 1 == cb);
          e.err   = 1'b0;
          pending_q.push_back(e);
        end
      end
    endfunction

    function void check(c_elem_t got);
      c_elem_t exp_e;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: value %0d row %0d col %0d last %0b err %0b",
                   got.value, got.row, got.col, got.last, got.err);
        return;
      end
      exp_e = pending_q.pop_front();
      if (got !== exp_e) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp %0d r%0d c%0d l%0b e%0b got %0d r%0d c%0d l%0b e%0b",
                   exp_e.value, exp_e.row, exp_e.col, exp_e.last, exp_e.err,
                   got.value, got.row, got.col, got.last, got.err);
      end
    endfunction

    function int unsigned pending();
      return pending_q.size();
    endfunction
  endclass

  logic                        clk_i;
  logic                        rst_ni;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [PADDR_W-1:0]          paddr;
  logic [PDATA_W-1:0]          pwdata;
  logic [PDATA_W-1:0]          prdata;
  logic                        pready;
  logic                        start;
  logic                        busy;
  logic signed [ELEM_BITS-1:0] element_i;
  logic                        result_valid_o;
  logic signed [RES_W-1:0]     product_value_o;
  logic [2:0]                  out_row_o;
  logic [2:0]                  out_col_o;
  logic                        last_o;
  logic                        dim_error_o;

  prod_board   board;
  int unsigned sent;
  bit          no_gaps;

  integer_matrix_multiply dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .start          (start),
    .busy           (busy),
    .element_i      (element_i),
    .result_valid_o (result_valid_o),
    .product_value_o(product_value_o),
    .out_row_o      (out_row_o),
    .out_col_o      (out_col_o),
    .last_o         (last_o),
    .dim_error_o    (dim_error_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o)
      board.check({product_value_o, out_row_o, out_col_o, last_o, dim_error_o});
  end

  function automatic logic signed [ELEM_BITS-1:0] rand_elem();
    case ($urandom_range(0, 7))
      0: return {1'b1, {(ELEM_BITS-1){1'b0}}};
      1: return {1'b0, {(ELEM_BITS-1){1'b1}}};
      default: return ELEM_BITS'($urandom);
    endcase
  endfunction

  task automatic send_word(logic signed [ELEM_BITS-1:0] w);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start     <= 1'b1;
    element_i <= w;
    do @(posedge clk_i); while (busy);
    board.note_word(w);
    sent++;
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    do @(posedge clk_i); while (board.pending() > 0 || busy);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_dim(cfg_reg_e r, logic [CFG_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({r, 2'b00});
    pwdata  <= {28'($urandom), v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    board.set_dim(r, v);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_shape(logic [CFG_W-1:0] ra, logic [CFG_W-1:0] ca,
                           logic [CFG_W-1:0] rb, logic [CFG_W-1:0] cb);
    wait_drain();
    write_dim(REG_ROWS_A, ra);
    write_dim(REG_COLS_A, ca);
    write_dim(REG_ROWS_B, rb);
    write_dim(REG_COLS_B, cb);
  endtask

  function automatic logic [CFG_W-1:0] pick_dim(bit big);
    if (big) return CFG_W'($urandom_range(8, 15));
    return CFG_W'($urandom_range(0, 4));
  endfunction

  task automatic random_phase();
    bit               big;
    logic [CFG_W-1:0] ra, ca, rb, cb;
    int unsigned      runs, words;
    big = ($urandom_range(0, 11) == 0);
    ra  = pick_dim(big);
    ca  = pick_dim(big);
    cb  = pick_dim(big);
    case ($urandom_range(0, 9))
      0:       rb = pick_dim(big);
      1:       rb = (ca == 0) ? 4'd1 : (ca == 1) ? 4'd0 : ca;
      default: rb = ca;
    endcase
    set_shape(ra, ca, rb, cb);
    no_gaps = ($urandom_range(0, 2) == 0);
    runs    = big ? 1 : $urandom_range(1, 3);
    for (int r = 0; r < runs; r++) begin
      words = board.run_words();
      if (words == 0) words = $urandom_range(1, 6);
      else if (words > 1 && r == runs - 1 && $urandom_range(0, 7) == 0)
        words = $urandom_range(1, words - 1);
      repeat (words) send_word(rand_elem());
      if ($urandom_range(0, 2) == 0) wait_drain();
    end
  endtask

  initial begin
    board     = new();
    sent      = 0;
    no_gaps   = 1'b0;
    rst_ni    = 1'b0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    start     <= 1'b0;
    element_i <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset shape 1x1 by 1x1: extreme element products
    send_word(16'sh8000);
    send_word(16'sh8000);
    send_word(16'sh7fff);
    send_word(16'sh8000);

    // clamped shape: zero reads as one, above eight reads as eight
    set_shape(4'd0, 4'd15, 4'd9, 4'd0);
    repeat (16) send_word(16'sh8000);

    // inner mismatch: every word is rejected
    set_shape(4'd1, 4'd3, 4'd2, 4'd1);
    send_word(16'sh7fff);
    send_word(16'sh0000);

    // partial run dropped by a register write
    set_shape(4'd2, 4'd2, 4'd2, 4'd2);
    repeat (3) send_word(rand_elem());
    set_shape(4'd1, 4'd2, 4'd2, 4'd1);
    repeat (4) send_word(rand_elem());

    while (sent < N_WORDS) random_phase();

    wait_drain();
    repeat (10) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #(20 * 400000);
    $display("simulation failed");
    $finish;
  end

endmodule
